// File: rtl/core/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Shared widths, defaults, command codes and the calibrated channel centers
// for the multi-channel servo slew limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

  // Default build parameters
  localparam int DefChannels = 16;
  localparam int DefFracBits = 16;

  // Field widths
  localparam int PulseW   = 12;
  localparam int ChanW    = 4;
  localparam int RateW    = 24;
  localparam int ElapsedW = 20;
  localparam int RateFrac = 24;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgMinPulse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPulse = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRate     = 2'd2;

  // Register reset values
  localparam logic [PulseW-1:0] MinPulseRst = 12'd200;
  localparam logic [PulseW-1:0] MaxPulseRst = 12'd410;
  localparam logic [RateW-1:0]  RateRst     = 24'd878;

  // Request function codes
  localparam logic FuncSetTarget = 1'b0;
  localparam logic FuncTick      = 1'b1;

  // Calibrated center pulse of a channel; channels past the sixteenth
  // share one default center.
  function automatic logic [PulseW-1:0] center_pulse(input int unsigned idx);
    logic [PulseW-1:0] c;
    case (idx)
      0:       c = 12'd311;
      1:       c = 12'd308;
      2:       c = 12'd293;
      3:       c = 12'd0;
      4:       c = 12'd313;
      5:       c = 12'd296;
      6:       c = 12'd328;
      7:       c = 12'd0;
      8:       c = 12'd335;
      9:       c = 12'd317;
      10:      c = 12'd325;
      11:      c = 12'd0;
      12:      c = 12'd327;
      13:      c = 12'd309;
      14:      c = 12'd322;
      15:      c = 12'd0;
      default: c = 12'd305;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/msl_if.sv
// ----------------------------------------------------------------------------
// msl_if
// Valid/ready channels of the servo slew limiter: the request channel
// (set target or tick) and the per-channel result channel.
// ----------------------------------------------------------------------------
interface msl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [msl_pkg::ChanW-1:0]    channel;
  logic [msl_pkg::PulseW-1:0]   position;
  logic [msl_pkg::ElapsedW-1:0] elapsed_us;

  modport source (output valid, func, channel, position, elapsed_us, input ready);
  modport sink   (input valid, func, channel, position, elapsed_us, output ready);
endinterface

interface msl_out_if;
  logic                       valid;
  logic                       ready;
  logic [msl_pkg::ChanW-1:0]  channel_out;
  logic [msl_pkg::PulseW-1:0] pulse_width;
  logic                       moving;
  logic                       accepted;
  logic                       all_done;
  logic                       last;

  modport source (output valid, channel_out, pulse_width, moving, accepted, all_done, last,
                  input ready);
  modport sink   (input valid, channel_out, pulse_width, moving, accepted, all_done, last,
                  output ready);
endinterface

// File: rtl/core/multi_servo_slew_limiter.sv
// ----------------------------------------------------------------------------
// multi_servo_slew_limiter
// Rate-limited pulse positions for a bank of servo channels.
// ----------------------------------------------------------------------------
// Takes one request at a time. A set-target request reads the channel
// entry from the state memory in the accept cycle, then, once the result
// slot is free, checks the pulse window, writes back and loads its result.
// In a tick the step (rate times elapsed) is multiplied and registered in
// the accept cycle while channel 0 is read, then one channel per cycle,
// while the result side does not stall, passes through the memory's single
// read port and write port, reading the next channel while the current one
// is moved and written back. State comes out of reset at the calibrated
// centers at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module multi_servo_slew_limiter #(
  parameter int CHANNELS  = msl_pkg::DefChannels,
  parameter int FRAC_BITS = msl_pkg::DefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  msl_in_if.sink                        in_req,
  msl_out_if.source                     out_rsp,
  input  logic                          cfg_we_i,
  input  logic [msl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msl_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PosW  = msl_pkg::PulseW + FRAC_BITS;
  localparam int ProdW = msl_pkg::RateW + msl_pkg::ElapsedW;
  localparam int Shift = msl_pkg::RateFrac - FRAC_BITS;
  localparam int StepW = ProdW - Shift;
  localparam logic [IdxW-1:0] MaxIdx = IdxW'(CHANNELS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StSet,
    StTick
  } state_e;

  // Configuration registers
  logic [msl_pkg::PulseW-1:0] min_q, max_q;
  logic [msl_pkg::RateW-1:0]  rate_q;

  // Sequencer state
  state_e                     state_q, state_d;
  logic [msl_pkg::ChanW-1:0]  chan_q, chan_d;
  logic [msl_pkg::PulseW-1:0] pos_q, pos_d;
  logic                       bad_q, bad_d;
  logic [ProdW-1:0]           prod_q, prod_d;
  logic                       done_q, done_d;
  logic [IdxW-1:0]            idx_q, idx_d;

  // Result register
  logic                       ov_q, ov_d;
  logic [msl_pkg::ChanW-1:0]  och_q, och_d;
  logic [msl_pkg::PulseW-1:0] opw_q, opw_d;
  logic                       omv_q, omv_d;
  logic                       oacc_q, oacc_d;
  logic                       odone_q, odone_d;
  logic                       olast_q, olast_d;

  // Memory ports
  logic                       rd_en, wr_en;
  logic [IdxW-1:0]            rd_addr, wr_addr;
  logic [PosW-1:0]            rd_cur, wr_cur;
  logic [msl_pkg::PulseW-1:0] rd_tgt, wr_tgt;

  // Datapath
  logic                       in_fire, out_free, in_bad;
  logic [StepW-1:0]           step;
  logic [PosW-1:0]            tgt_fix, diff, tick_cur;
  logic                       cur_lt, reach, tick_mv, tick_last;
  logic                       set_acc;
  logic [msl_pkg::PulseW-1:0] set_tgt;
  logic                       set_mv;

  msl_chan_store #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_cur_o  (rd_cur),
    .rd_tgt_o  (rd_tgt),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_cur_i  (wr_cur),
    .wr_tgt_i  (wr_tgt)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= msl_pkg::MinPulseRst;
      max_q  <= msl_pkg::MaxPulseRst;
      rate_q <= msl_pkg::RateRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msl_pkg::CfgMinPulse: min_q  <= cfg_wdata_i[msl_pkg::PulseW-1:0];
        msl_pkg::CfgMaxPulse: max_q  <= cfg_wdata_i[msl_pkg::PulseW-1:0];
        msl_pkg::CfgRate:     rate_q <= cfg_wdata_i[msl_pkg::RateW-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !ov_q || out_rsp.ready;
  assign in_bad   = int'(in_req.channel) >= CHANNELS;

  // Move one channel toward its target by at most one step
  assign step      = prod_q[ProdW-1:Shift];
  assign tgt_fix   = {rd_tgt, {FRAC_BITS{1'b0}}};
  assign cur_lt    = rd_cur < tgt_fix;
  assign diff      = cur_lt ? (tgt_fix - rd_cur) : (rd_cur - tgt_fix);
  assign reach     = StepW'(diff) <= step;
  assign tick_cur  = reach ? tgt_fix
                   : (cur_lt ? (rd_cur + PosW'(step)) : (rd_cur - PosW'(step)));
  assign tick_mv   = rd_cur != tgt_fix;
  assign tick_last = idx_q == MaxIdx;

  // Window check for a new target
  assign set_acc = !bad_q && (pos_q >= min_q) && (pos_q <= max_q);
  assign set_tgt = set_acc ? pos_q : rd_tgt;
  assign set_mv  = rd_cur != {set_tgt, {FRAC_BITS{1'b0}}};

  // Sequencer: read, modify, write back, load the result
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    pos_d   = pos_q;
    bad_d   = bad_q;
    prod_d  = prod_q;
    done_d  = done_q;
    idx_d   = idx_q;
    ov_d    = ov_q && !out_rsp.ready;
    och_d   = och_q;
    opw_d   = opw_q;
    omv_d   = omv_q;
    oacc_d  = oacc_q;
    odone_d = odone_q;
    olast_d = olast_q;
    rd_en   = 1'b0;
    rd_addr = idx_q + IdxW'(1);
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_cur  = rd_cur;
    wr_tgt  = rd_tgt;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          chan_d  = in_req.channel;
          pos_d   = in_req.position;
          bad_d   = in_bad;
          prod_d  = ProdW'(rate_q) * ProdW'(in_req.elapsed_us);
          done_d  = 1'b1;
          idx_d   = '0;
          rd_en   = 1'b1;
          if (in_req.func == msl_pkg::FuncTick) begin
            rd_addr = '0;
            state_d = StTick;
          end else begin
            rd_addr = IdxW'(in_req.channel);
            state_d = StSet;
          end
        end
      end
      StSet: begin
        if (out_free) begin
          wr_en   = set_acc;
          wr_addr = IdxW'(chan_q);
          wr_tgt  = set_tgt;
          ov_d    = 1'b1;
          och_d   = chan_q;
          opw_d   = bad_q ? '0 : rd_cur[PosW-1:FRAC_BITS];
          omv_d   = !bad_q && set_mv;
          oacc_d  = set_acc;
          odone_d = 1'b0;
          olast_d = 1'b1;
          state_d = StIdle;
        end
      end
      StTick: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_cur  = tick_cur;
          done_d  = done_q && !tick_mv;
          ov_d    = 1'b1;
          och_d   = msl_pkg::ChanW'(idx_q);
          opw_d   = tick_cur[PosW-1:FRAC_BITS];
          omv_d   = tick_mv;
          oacc_d  = 1'b0;
          odone_d = tick_last && done_q && !tick_mv;
          olast_d = tick_last;
          if (tick_last) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + IdxW'(1);
            rd_en = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      done_q  <= 1'b1;
      ov_q    <= 1'b0;
      och_q   <= '0;
      opw_q   <= '0;
      omv_q   <= 1'b0;
      oacc_q  <= 1'b0;
      odone_q <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      ov_q    <= ov_d;
      och_q   <= och_d;
      opw_q   <= opw_d;
      omv_q   <= omv_d;
      oacc_q  <= oacc_d;
      odone_q <= odone_d;
      olast_q <= olast_d;
    end
  end

  // Hold the request fields and the step product
  always_ff @(posedge clk_i) begin
    chan_q  <= chan_d;
    pos_q   <= pos_d;
    bad_q   <= bad_d;
    prod_q  <= prod_d;
  end

  assign in_req.ready        = state_q == StIdle;
  assign out_rsp.valid       = ov_q;
  assign out_rsp.channel_out = och_q;
  assign out_rsp.pulse_width = opw_q;
  assign out_rsp.moving      = omv_q;
  assign out_rsp.accepted    = oacc_q;
  assign out_rsp.all_done    = odone_q;
  assign out_rsp.last        = olast_q;

  // Read and write of one cycle never touch the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("read and write collide on one channel entry");

  // One request in flight: ready drops after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_req.ready)
    else $error("request accepted while another is in work");

  // The tick walk stays inside the channel range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StTick |-> idx_q <= MaxIdx)
    else $error("tick index past last channel");

  // Settled flag only rides on the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && odone_q |-> olast_q && !oacc_q)
    else $error("all_done on a non-final result");

  // A new result is loaded only into a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_rsp.ready |=> ov_q && $stable(och_q) && $stable(olast_q))
    else $error("pending result overwritten");

endmodule

// File: rtl/core/msl_chan_store.sv
// ----------------------------------------------------------------------------
// msl_chan_store
// Per-channel state memory: current position and target pulse in one
// entry, one read port with registered data and one write port. Entries
// never written read back as the calibrated center of their channel.
// ----------------------------------------------------------------------------
module msl_chan_store #(
  parameter int CHANNELS  = msl_pkg::DefChannels,
  parameter int FRAC_BITS = msl_pkg::DefFracBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr_i,
  output logic [msl_pkg::PulseW+FRAC_BITS-1:0]  rd_cur_o,
  output logic [msl_pkg::PulseW-1:0]            rd_tgt_o,
  input  logic                                  wr_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr_i,
  input  logic [msl_pkg::PulseW+FRAC_BITS-1:0]  wr_cur_i,
  input  logic [msl_pkg::PulseW-1:0]            wr_tgt_i
);

  localparam int IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PosW  = msl_pkg::PulseW + FRAC_BITS;
  localparam int WordW = PosW + msl_pkg::PulseW;

  logic [WordW-1:0]    mem [CHANNELS];
  logic [WordW-1:0]    rd_word_q;
  logic [IdxW-1:0]     rd_addr_q;
  logic                rd_vld_q;
  logic [CHANNELS-1:0] vld_q;
  logic [msl_pkg::PulseW-1:0] ctr;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_cur_i, wr_tgt_i};
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q <= mem[rd_addr_i];
    end
  end

  // Track written entries; reset marks every entry as holding its center
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        rd_addr_q <= rd_addr_i;
      end
    end
  end

  // Substitute the center for entries never written
  assign ctr      = msl_pkg::center_pulse(int'(rd_addr_q));
  assign rd_cur_o = rd_vld_q ? rd_word_q[WordW-1:msl_pkg::PulseW] : {ctr, {FRAC_BITS{1'b0}}};
  assign rd_tgt_o = rd_vld_q ? rd_word_q[msl_pkg::PulseW-1:0] : ctr;

endmodule
